[hw/rtl/ptd_pkg.sv]
// ============================================================================
// ptd_pkg: shared types and constants for the periodic task dispatcher
// Holds the slot count, command codes, controller states and the command
// and status bundles that pass between the controller and the datapath.
// ============================================================================
package ptd_pkg;

    // Number of task slots in the table. Only the first eight can be named
    // by the 3-bit slot field, so storage is capped at eight entries.
    localparam int NUM_SLOTS  = 8;
    localparam int SLOT_COUNT = (NUM_SLOTS < 8) ? NUM_SLOTS : 8;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Field widths of the item and result beats.
    localparam int CMD_W    = 3;
    localparam int SEL_W    = 3;
    localparam int PERIOD_W = 16;
    localparam int COUNT_W  = 16;
    localparam int MASK_W   = 8;
    localparam int BIT_W    = $clog2(COUNT_W);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SUSPEND = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } ptd_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic check;
        logic div_step;
        logic load_out;
    } ptd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic eligible;
        logic last_slot;
        logic div_last;
        logic out_free;
    } ptd_stat_t;

endpackage

[hw/rtl/periodic_task_dispatcher_core.sv]
// ============================================================================
// periodic_task_dispatcher_core: time-triggered cooperative scheduler core
// Keeps a table of task slots and a 16-bit tick counter, applies one command
// per input beat and returns one result beat with the due mask of a tick.
// ============================================================================
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-------------------------------------
//   s_      | in        | s_valid / s_ready  | s_command[2:0] s_slot[2:0] s_period[15:0]
//   m_      | out       | m_valid / m_ready  | m_due_mask[7:0] m_accepted m_tick_count[15:0]
//
// A create, delete, suspend, resume or unknown command goes from acceptance
// through the execute and done states to its result beat. A tick also runs a
// check of each slot in turn; for each slot that is present, running and has a
// nonzero period, the shared remainder unit retires one counter bit per
// cycle, sixteen bits per slot, to decide whether the slot is due.
// Synchronous active-low reset clears the tick counter, all present and
// running marks and the result valid; it needs no clearing pass.
// The block takes one item at a time. A finished result sits in the output
// register while the next item is already accepted and worked on; only
// when that next result is ready and m_ready is still low does the block stall.
//
module periodic_task_dispatcher_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ptd_pkg::CMD_W-1:0]         s_command,
    input  logic [ptd_pkg::SEL_W-1:0]         s_slot,
    input  logic [ptd_pkg::PERIOD_W-1:0]      s_period,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ptd_pkg::MASK_W-1:0]        m_due_mask,
    output logic                              m_accepted,
    output logic [ptd_pkg::COUNT_W-1:0]       m_tick_count
);
    import ptd_pkg::*;

    // Command bundle from the controller and status bundle back from the
    // datapath; these are the only signals between the two halves.
    ptd_cmd_t  cmd;
    ptd_stat_t stat;

    // The controller owns s_ready: the block is open for a new beat whenever
    // it is idle, independent of whether the output register is occupied.
    ptd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // The datapath holds the slot table, the tick counter, the serial
    // remainder unit and the result register that drives the m_ channel.
    ptd_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_command    (s_command),
        .s_slot       (s_slot),
        .s_period     (s_period),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_due_mask   (m_due_mask),
        .m_accepted   (m_accepted),
        .m_tick_count (m_tick_count),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

[hw/rtl/ptd_ctrl.sv]
// ============================================================================
// ptd_ctrl: sequencing controller of the periodic task dispatcher
// Walks one item through execute, for a tick the per-slot divisibility scan, and the
// hand-off to the result register.
// ============================================================================
module ptd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output ptd_pkg::ptd_cmd_t cmd,
    input  ptd_pkg::ptd_stat_t stat
);
    import ptd_pkg::*;

    ptd_state_t state_reg;
    ptd_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = stat.is_tick ? ST_CHECK : ST_DONE;
            end
            ST_CHECK: begin
                if (stat.eligible) begin
                    state_next = ST_DIV;
                end else if (stat.last_slot) begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                if (stat.div_last) begin
                    state_next = stat.last_slot ? ST_DONE : ST_CHECK;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_DONE: begin
                cmd.load_out = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[hw/rtl/ptd_datapath.sv]
// ============================================================================
// ptd_datapath: slot table, tick counter and serial remainder unit
// Applies commands to the slot table and tests each slot's period against
// the tick counter with a one-bit-per-cycle restoring remainder.
// ============================================================================
module ptd_datapath (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic [ptd_pkg::CMD_W-1:0]               s_command,
    input  logic [ptd_pkg::SEL_W-1:0]               s_slot,
    input  logic [ptd_pkg::PERIOD_W-1:0]            s_period,
    input  logic                                    m_ready,
    output logic                                    m_valid,
    output logic [ptd_pkg::MASK_W-1:0]              m_due_mask,
    output logic                                    m_accepted,
    output logic [ptd_pkg::COUNT_W-1:0]             m_tick_count,
    input  ptd_pkg::ptd_cmd_t                       cmd,
    output ptd_pkg::ptd_stat_t                      stat
);
    import ptd_pkg::*;

    // Captured item.
    logic [CMD_W-1:0]    op_reg,  op_next;
    logic [SEL_W-1:0]    sel_reg, sel_next;
    logic [PERIOD_W-1:0] per_reg, per_next;

    // Scheduler state.
    logic [COUNT_W-1:0]  tick_cnt_reg, tick_cnt_next;
    logic                present_reg [SLOT_COUNT];
    logic                present_next [SLOT_COUNT];
    logic                running_reg [SLOT_COUNT];
    logic                running_next [SLOT_COUNT];
    logic [PERIOD_W-1:0] period_reg [SLOT_COUNT];
    logic [PERIOD_W-1:0] period_next [SLOT_COUNT];

    // Scan and remainder state.
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [MASK_W-1:0]   mask_reg, mask_next;
    logic                ok_reg, ok_next;

    // Result register.
    logic                out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]   out_mask_reg, out_mask_next;
    logic                out_ok_reg, out_ok_next;
    logic [COUNT_W-1:0]  out_cnt_reg, out_cnt_next;

    logic                slot_ok;
    logic [SLOT_W-1:0]   slot_sel;
    logic [PERIOD_W-1:0] period_rd;
    logic [PERIOD_W:0]   trial;
    logic                trial_ge;
    logic [PERIOD_W-1:0] rem_new;
    logic                is_tick;
    logic                eligible;
    logic [SLOT_COUNT-1:0] live_vec;

    assign is_tick   = (op_reg == CMD_TICK);
    assign slot_ok   = (32'(sel_reg) < NUM_SLOTS);
    assign slot_sel  = sel_reg[SLOT_W-1:0];
    assign period_rd = period_reg[idx_reg];
    assign eligible  = present_reg[idx_reg] && running_reg[idx_reg] && (period_rd != '0);

    // One restoring step: shift in the next counter bit, subtract if it fits.
    assign trial    = {rem_reg, tick_cnt_reg[bit_reg]};
    assign trial_ge = (trial >= {1'b0, period_rd});
    assign rem_new  = trial_ge ? PERIOD_W'(trial - {1'b0, period_rd}) : trial[PERIOD_W-1:0];

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            live_vec[i] = present_reg[i] && running_reg[i];
        end
    end

    assign stat.is_tick   = is_tick;
    assign stat.eligible  = eligible;
    assign stat.last_slot = (idx_reg == SLOT_W'(SLOT_COUNT - 1));
    assign stat.div_last  = (bit_reg == '0);
    assign stat.out_free  = !out_valid_reg || m_ready;

    always_comb begin
        op_next       = op_reg;
        sel_next      = sel_reg;
        per_next      = per_reg;
        tick_cnt_next = tick_cnt_reg;
        present_next  = present_reg;
        running_next  = running_reg;
        period_next   = period_reg;
        idx_next      = idx_reg;
        bit_next      = bit_reg;
        rem_next      = rem_reg;
        mask_next     = mask_reg;
        ok_next       = ok_reg;

        if (cmd.capture) begin
            op_next  = s_command;
            sel_next = s_slot;
            per_next = s_period;
        end

        if (cmd.exec) begin
            mask_next = '0;
            ok_next   = 1'b1;
            idx_next  = '0;
            case (op_reg)
                CMD_TICK: begin
                    tick_cnt_next = tick_cnt_reg + 1'b1;
                end
                CMD_CREATE: begin
                    if (slot_ok && !present_reg[slot_sel]) begin
                        present_next[slot_sel] = 1'b1;
                        running_next[slot_sel] = 1'b1;
                        period_next[slot_sel]  = per_reg;
                    end else begin
                        ok_next = 1'b0;
                    end
                end
                CMD_DELETE: begin
                    if (slot_ok) begin
                        present_next[slot_sel] = 1'b0;
                    end
                end
                CMD_SUSPEND: begin
                    if (slot_ok) begin
                        running_next[slot_sel] = 1'b0;
                    end
                end
                CMD_RESUME: begin
                    if (slot_ok) begin
                        running_next[slot_sel] = 1'b1;
                    end
                end
                default: begin
                    ok_next = 1'b1;
                end
            endcase
        end

        if (cmd.check) begin
            if (eligible) begin
                rem_next = '0;
                bit_next = BIT_W'(COUNT_W - 1);
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end

        if (cmd.div_step) begin
            rem_next = rem_new;
            bit_next = bit_reg - 1'b1;
            if (bit_reg == '0) begin
                if (rem_new == '0) begin
                    mask_next = mask_reg | (MASK_W'(1) << idx_reg);
                end
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_comb begin
        out_mask_next  = out_mask_reg;
        out_ok_next    = out_ok_reg;
        out_cnt_next   = out_cnt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
            out_mask_next  = mask_reg;
            out_ok_next    = ok_reg;
            out_cnt_next   = tick_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                present_reg[i] <= 1'b0;
                running_reg[i] <= 1'b0;
            end
        end else begin
            tick_cnt_reg  <= tick_cnt_next;
            out_valid_reg <= out_valid_next;
            mask_reg      <= mask_next;
            present_reg   <= present_next;
            running_reg   <= running_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        sel_reg      <= sel_next;
        per_reg      <= per_next;
        period_reg   <= period_next;
        idx_reg      <= idx_next;
        bit_reg      <= bit_next;
        rem_reg      <= rem_next;
        ok_reg       <= ok_next;
        out_mask_reg <= out_mask_next;
        out_ok_reg   <= out_ok_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_due_mask   = out_mask_reg;
    assign m_accepted   = out_ok_reg;
    assign m_tick_count = out_cnt_reg;

    // The partial remainder always stays below the divisor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (rem_reg < period_rd))
        else $error("ptd_datapath: partial remainder not below period");

    // A result is only loaded when the result register can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_ready))
        else $error("ptd_datapath: result register overwritten");

    // Only present, running slots may ever collect a due bit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mask_reg[SLOT_COUNT-1:0] & ~live_vec) == '0)
        else $error("ptd_datapath: due bit on an idle slot");

    // The tick counter moves only when a tick is executed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !(cmd.exec && is_tick)) |=> (tick_cnt_reg == $past(tick_cnt_reg)))
        else $error("ptd_datapath: tick counter changed outside a tick");

endmodule
